FILE: rtl/core/mluf_pkg.sv
// Shared constants and helper functions for the MUSCL upwind face flux block.
`timescale 1ns / 1ps

package mluf_pkg;

  localparam int FRAC_BITS_DEF    = 24;
  localparam int VALUE_WIDTH_DEF  = 32;
  // radix-4 digits resolved per divide-by-three stage
  localparam int DIGITS_PER_STAGE = 8;

  function automatic int div3_digits(input int width);
    return (width + 1) / 2;
  endfunction

  function automatic int div3_stages(input int width);
    return (div3_digits(width) + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;
  endfunction

  // One radix-4 long-division step by three: {rem, digit} -> {quotient digit, rem}
  function automatic logic [3:0] div3_step(input logic [3:0] v);
    logic [3:0] qr;
    case (v)
      4'd0:    qr = {2'd0, 2'd0};
      4'd1:    qr = {2'd0, 2'd1};
      4'd2:    qr = {2'd0, 2'd2};
      4'd3:    qr = {2'd1, 2'd0};
      4'd4:    qr = {2'd1, 2'd1};
      4'd5:    qr = {2'd1, 2'd2};
      4'd6:    qr = {2'd2, 2'd0};
      4'd7:    qr = {2'd2, 2'd1};
      4'd8:    qr = {2'd2, 2'd2};
      4'd9:    qr = {2'd3, 2'd0};
      4'd10:   qr = {2'd3, 2'd1};
      4'd11:   qr = {2'd3, 2'd2};
      default: qr = 4'd0;
    endcase
    return qr;
  endfunction

endpackage

FILE: rtl/core/muscl_limited_upwind_face_flux_top.sv
// Top level: MUSCL kappa=1/3 minmod-limited upwind face flux, fully pipelined.
`timescale 1ns / 1ps

// Channel  | Handshake            | Word
// ---------+----------------------+--------------------------------------------
// in       | start / busy         | far/near upwind, near/far downwind, velocity
// out      | out_valid (1 cycle)  | face_flux, saturated
// cfg      | cfg_wr_en            | cfg_wr_data = second_order_enable
//
// One word accepted per clock while busy is low.
// The divide-by-three pipeline resolves eight radix-4 digits per stage.
// Synchronous reset clears all valid bits and sets second_order_enable to 1; busy is
// high only during reset. Results show for exactly one cycle on out_valid and are never
// held back, so the pipeline never stalls.

module muscl_limited_upwind_face_flux_top #(
  parameter int FRAC_BITS   = mluf_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = mluf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_far_upwind_value,
  input  logic signed [VALUE_WIDTH-1:0] in_near_upwind_value,
  input  logic signed [VALUE_WIDTH-1:0] in_near_downwind_value,
  input  logic signed [VALUE_WIDTH-1:0] in_far_downwind_value,
  input  logic signed [VALUE_WIDTH-1:0] in_face_velocity,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_face_flux,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);
  import mluf_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int DW  = W + 1;             // stencil differences
  localparam int NW  = W + 3;             // limited slope sum
  localparam int TW  = W + 1;             // divide-by-three operand
  localparam int PHW = W + 2;             // reconstructed face state
  localparam int H   = (W + 1) / 2;       // multiplier split point
  localparam int PW  = 2 * W + 1;         // exact product magnitude
  localparam int RW  = ((PW > FRAC_BITS) ? PW : FRAC_BITS) + 1;
  localparam int S   = div3_stages(TW);
  localparam int LAT = 11 + S;
  localparam int SBW = 3 + 2 * W;

  localparam logic [RW-1:0] HALF    = RW'(1) << (FRAC_BITS - 1);
  localparam logic [RW-1:0] LIM_NEG = RW'(1) << (W - 1);
  localparam logic [RW-1:0] LIM_POS = LIM_NEG - RW'(1);
  localparam logic [W-1:0]  FLUX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  FLUX_MIN = {1'b1, {(W-1){1'b0}}};

  // minmod(x, 4y) with sgn(0) = +1
  function automatic logic signed [DW-1:0] minmod4(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] y);
    logic signed [DW+1:0] y4;
    logic signed [DW+1:0] xe;
    logic                 y4_pos;
    logic                 y4_neg;
    y4     = {y, 2'b00};
    xe     = (DW+2)'(x);
    y4_neg = y4[DW+1];
    y4_pos = !y4[DW+1] && (y4 != '0);
    if (!x[DW-1]) begin
      if (!y4_pos) minmod4 = '0;
      else if (xe < y4) minmod4 = x;
      else minmod4 = DW'(y4);
    end else begin
      if (!y4_neg) minmod4 = '0;
      else if (xe > y4) minmod4 = x;
      else minmod4 = DW'(y4);
    end
  endfunction

  logic accept;
  logic so_r;

  // stage 1: stencil differences
  logic                 v1_r, so1_r, uneg1_r;
  logic signed [DW-1:0] s1_r, o1_r;
  logic signed [W-1:0]  base1_r;
  logic [W-1:0]         magu1_r;
  logic                 uneg_nxt;
  logic signed [DW-1:0] s_nxt, o_nxt;
  logic [W-1:0]         magu_nxt;

  // stage 2: limited slopes
  logic                 v2_r, so2_r, uneg2_r;
  logic signed [DW-1:0] l1_r, l2_r;
  logic signed [W-1:0]  base2_r;
  logic [W-1:0]         magu2_r;

  // stage 3: slope sum
  logic                 v3_r, so3_r, uneg3_r;
  logic signed [NW-1:0] n3_r;
  logic signed [W-1:0]  base3_r;
  logic [W-1:0]         magu3_r;

  // stage 4: rounded magnitude / 2
  logic                 v4_r, so4_r, uneg4_r, nneg4_r;
  logic [TW-1:0]        t4_r;
  logic signed [W-1:0]  base4_r;
  logic [W-1:0]         magu4_r;
  logic signed [NW-1:0] adj;

  // divider and aligned sideband
  logic                 div_vld;
  logic [TW-1:0]        div_q;
  logic [SBW-1:0]       sbd_r [S];
  logic                 so_q, uneg_q, nneg_q;
  logic signed [W-1:0]  base_q;
  logic [W-1:0]         magu_q;

  // stage 5: face state
  logic                  v5_r, uneg5_r;
  logic signed [PHW-1:0] phi5_r;
  logic [W-1:0]          magu5_r;
  logic signed [PHW-1:0] bext, qext, phi_nxt;

  // stage 6: magnitudes
  logic                  v6_r, neg6_r;
  logic [W:0]            magp6_r;
  logic [W-1:0]          magu6_r;

  // stage 7: partial products
  logic                   v7_r, neg7_r;
  logic [2*H-1:0]         pll7_r;
  logic [W:0]             plh7_r;
  logic [W-1:0]           phl7_r;
  logic [PW-2*H-1:0]      phh7_r;

  // stage 8: cross sum
  logic                   v8_r, neg8_r;
  logic [W+1:0]           cross8_r;
  logic [PW-1:0]          hl8_r;

  // stage 9: rounded product
  logic                   v9_r, neg9_r;
  logic [RW-1:0]          r9_r;

  // stage 10: saturation
  logic                   v10_r, neg10_r, sat10_r;
  logic [W-1:0]           mag10_r;
  logic [RW-1:0]          rnd, lim;
  logic                   sat_nxt;

  // output word
  logic                   out_vld_r, out_sat_r;
  logic [W-1:0]           flux_r;

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r <= 1'b1;
    end else if (cfg_wr_en) begin
      so_r <= cfg_wr_data;
    end
  end

  // upwind side picks the stencil: o is always C-B, s is B-A or D-C
  always_comb begin
    uneg_nxt = in_face_velocity[W-1];
    s_nxt    = uneg_nxt ? (DW'(in_far_downwind_value) - DW'(in_near_downwind_value))
                        : (DW'(in_near_upwind_value) - DW'(in_far_upwind_value));
    o_nxt    = DW'(in_near_downwind_value) - DW'(in_near_upwind_value);
    magu_nxt = uneg_nxt ? (W'(0) - $unsigned(in_face_velocity))
                        : $unsigned(in_face_velocity);
  end

  always_comb begin
    adj = n3_r[NW-1] ? (NW'(3) - n3_r) : (n3_r + NW'(3));
  end

  mluf_div3 #(
    .WIDTH (TW)
  ) u_div3 (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v4_r),
    .in_dividend  (t4_r),
    .out_valid    (div_vld),
    .out_quotient (div_q)
  );

  always_ff @(posedge clk) begin
    sbd_r[0] <= {so4_r, uneg4_r, nneg4_r, base4_r, magu4_r};
    for (int i = 1; i < S; i++) begin
      sbd_r[i] <= sbd_r[i-1];
    end
  end

  assign so_q   = sbd_r[S-1][SBW-1];
  assign uneg_q = sbd_r[S-1][SBW-2];
  assign nneg_q = sbd_r[S-1][SBW-3];
  assign base_q = sbd_r[S-1][2*W-1:W];
  assign magu_q = sbd_r[S-1][W-1:0];

  // correction adds when slope-sum sign matches the upwind direction
  always_comb begin
    bext = PHW'(base_q);
    qext = $signed({1'b0, div_q});
    if (!so_q) phi_nxt = bext;
    else if (nneg_q == uneg_q) phi_nxt = bext + qext;
    else phi_nxt = bext - qext;
  end

  always_comb begin
    rnd     = r9_r >> FRAC_BITS;
    lim     = neg9_r ? LIM_NEG : LIM_POS;
    sat_nxt = rnd > lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      v7_r      <= 1'b0;
      v8_r      <= 1'b0;
      v9_r      <= 1'b0;
      v10_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      v1_r      <= accept;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= div_vld;
      v6_r      <= v5_r;
      v7_r      <= v6_r;
      v8_r      <= v7_r;
      v9_r      <= v8_r;
      v10_r     <= v9_r;
      out_vld_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    so1_r    <= so_r;
    uneg1_r  <= uneg_nxt;
    s1_r     <= s_nxt;
    o1_r     <= o_nxt;
    base1_r  <= uneg_nxt ? in_near_downwind_value : in_near_upwind_value;
    magu1_r  <= magu_nxt;

    so2_r    <= so1_r;
    uneg2_r  <= uneg1_r;
    l1_r     <= minmod4(s1_r, o1_r);
    l2_r     <= minmod4(o1_r, s1_r);
    base2_r  <= base1_r;
    magu2_r  <= magu1_r;

    so3_r    <= so2_r;
    uneg3_r  <= uneg2_r;
    n3_r     <= NW'(l1_r) + (NW'(l2_r) <<< 1);
    base3_r  <= base2_r;
    magu3_r  <= magu2_r;

    so4_r    <= so3_r;
    uneg4_r  <= uneg3_r;
    nneg4_r  <= n3_r[NW-1];
    t4_r     <= adj[TW:1];
    base4_r  <= base3_r;
    magu4_r  <= magu3_r;

    uneg5_r  <= uneg_q;
    phi5_r   <= phi_nxt;
    magu5_r  <= magu_q;

    neg6_r   <= uneg5_r ^ phi5_r[PHW-1];
    magp6_r  <= phi5_r[PHW-1] ? (W+1)'(-phi5_r) : (W+1)'(phi5_r);
    magu6_r  <= magu5_r;

    neg7_r   <= neg6_r;
    pll7_r   <= (2*H)'(magu6_r[H-1:0]) * (2*H)'(magp6_r[H-1:0]);
    plh7_r   <= (W+1)'(magu6_r[H-1:0]) * (W+1)'(magp6_r[W:H]);
    phl7_r   <= W'(magu6_r[W-1:H]) * W'(magp6_r[H-1:0]);
    phh7_r   <= (PW-2*H)'(magu6_r[W-1:H]) * (PW-2*H)'(magp6_r[W:H]);

    neg8_r   <= neg7_r;
    cross8_r <= (W+2)'(plh7_r) + (W+2)'(phl7_r);
    hl8_r    <= {phh7_r, pll7_r};

    neg9_r   <= neg8_r;
    r9_r     <= RW'(hl8_r) + (RW'(cross8_r) << H) + HALF;

    neg10_r  <= neg9_r;
    sat10_r  <= sat_nxt;
    mag10_r  <= sat_nxt ? lim[W-1:0] : rnd[W-1:0];

    out_sat_r <= sat10_r;
    flux_r    <= neg10_r ? (W'(0) - mag10_r) : mag10_r;
  end

  assign out_valid     = out_vld_r;
  assign out_face_flux = flux_r;
  assign out_saturated = out_sat_r;

  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without matching input word");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld |-> $past(v4_r, S))
    else $error("divider out of step with sideband delay");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_face_flux == FLUX_MAX || out_face_flux == FLUX_MIN))
    else $error("saturated flux not at a range bound");

endmodule

FILE: rtl/core/mluf_div3.sv
// Pipelined unsigned divide-by-three, radix-4 digits, several digits per stage.
`timescale 1ns / 1ps

module mluf_div3 #(
  parameter int WIDTH = mluf_pkg::VALUE_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_dividend,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_quotient
);
  import mluf_pkg::*;

  localparam int DIGITS = div3_digits(WIDTH);
  localparam int PADW   = 2 * DIGITS;
  localparam int STAGES = div3_stages(WIDTH);

  logic            vld_r [STAGES];
  logic [PADW-1:0] quo_r [STAGES];
  logic [PADW-1:0] num_r [STAGES-1];
  logic [1:0]      rem_r [STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int TOP = DIGITS - 1 - s * DIGITS_PER_STAGE;
    localparam int CNT = (TOP + 1 < DIGITS_PER_STAGE) ? TOP + 1 : DIGITS_PER_STAGE;

    logic            vld_in;
    logic [PADW-1:0] num_in;
    logic [PADW-1:0] quo_in;
    logic [PADW-1:0] quo_nxt;
    logic [1:0]      rem_in;
    logic [1:0]      rem_nxt;

    if (s == 0) begin : g_head
      assign vld_in = in_valid;
      assign num_in = PADW'(in_dividend);
      assign quo_in = '0;
      assign rem_in = '0;
    end else begin : g_body
      assign vld_in = vld_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign rem_in = rem_r[s-1];
    end

    // digits go most significant first; remainder chains through the stage
    always_comb begin
      logic [3:0] qr;
      quo_nxt = quo_in;
      rem_nxt = rem_in;
      qr      = '0;
      for (int k = 0; k < CNT; k++) begin
        qr = div3_step({rem_nxt, num_in[2*(TOP-k) +: 2]});
        quo_nxt[2*(TOP-k) +: 2] = qr[3:2];
        rem_nxt = qr[1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      quo_r[s] <= quo_nxt;
    end

    if (s < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        num_r[s] <= num_in;
        rem_r[s] <= rem_nxt;
      end
    end
  end

  assign out_valid    = vld_r[STAGES-1];
  assign out_quotient = quo_r[STAGES-1][WIDTH-1:0];

endmodule

FILE: tb/muscl_limited_upwind_face_flux_top_tb.sv
// Self-checking testbench for the MUSCL limited upwind face flux block.
`timescale 1ns / 1ps

module muscl_limited_upwind_face_flux_top_tb;

  localparam int W             = mluf_pkg::VALUE_WIDTH_DEF;
  localparam int FRAC          = mluf_pkg::FRAC_BITS_DEF;
  localparam int PIPE_LATENCY  = 14;
  localparam int STALL_LIMIT   = 2000;
  localparam logic signed [W-1:0] Q_ONE = 1 <<< FRAC;
  localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic signed [W-1:0] far_up;
    logic signed [W-1:0] near_up;
    logic signed [W-1:0] near_down;
    logic signed [W-1:0] far_down;
    logic signed [W-1:0] velocity;
  } stencil_t;

  typedef struct {
    logic signed [W-1:0] flux;
    logic                sat;
  } flux_t;

  class flux_scoreboard;
    bit    order_enable = 1'b1;
    flux_t pending_fluxes[$];
    int    errors = 0;
    int    n_second = 0;
    int    n_first = 0;
    int    n_sat = 0;
    int    n_still = 0;

    // minmod with compression 4, sgn(0) = +1
    function longint limit_slope(longint x, longint y);
      longint y4 = y * 4;
      longint r;
      if (x >= 0) begin
        r = (x < y4) ? x : y4;
        return (r > 0) ? r : 0;
      end
      r = (-x < -y4) ? -x : -y4;
      return (r > 0) ? -r : 0;
    endfunction

    // divide by six, nearest, ties away from zero
    function longint round_sixth(longint n);
      longint m = (n < 0) ? -n : n;
      longint q = (m + 3) / 6;
      return (n < 0) ? -q : q;
    endfunction

    function flux_t predict_face_flux(stencil_t s);
      longint a = s.far_up;
      longint b = s.near_up;
      longint c = s.near_down;
      longint d = s.far_down;
      longint uf = s.velocity;
      longint phi, dp, dm, lp, lm;
      logic [63:0]  mag_u, mag_p;
      logic [127:0] prod, lim;
      logic [W-1:0] mag;
      logic         neg;
      flux_t        r;
      if (uf >= 0) begin
        dp = c - b;
        dm = b - a;
        lp = limit_slope(dp, dm);
        lm = limit_slope(dm, dp);
        phi = b;
        if (order_enable) phi = phi + round_sixth(lm + 2 * lp);
      end else begin
        dp = d - c;
        dm = c - b;
        lp = limit_slope(dp, dm);
        lm = limit_slope(dm, dp);
        phi = c;
        if (order_enable) phi = phi - round_sixth(lp + 2 * lm);
      end
      neg   = (uf < 0) != (phi < 0);
      mag_u = (uf < 0) ? -uf : uf;
      mag_p = (phi < 0) ? -phi : phi;
      prod  = {64'd0, mag_u} * {64'd0, mag_p};
      prod  = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
      lim   = (128'd1 << (W - 1)) - (neg ? 128'd0 : 128'd1);
      r.sat = prod > lim;
      if (r.sat) prod = lim;
      mag    = prod[W-1:0];
      r.flux = neg ? -mag : mag;
      return r;
    endfunction

    function void note_stencil(stencil_t s);
      flux_t e = predict_face_flux(s);
      pending_fluxes.push_back(e);
      if (order_enable) n_second++;
      else n_first++;
      if (e.sat) n_sat++;
      if (s.velocity == 0) n_still++;
    endfunction

    function void check_flux(logic signed [W-1:0] flux, logic sat);
      flux_t e;
      if (pending_fluxes.size() == 0) begin
        $display("%0t: unexpected flux word: expected none, got flux %h sat %b",
                 $time, flux, sat);
        errors++;
        return;
      end
      e = pending_fluxes.pop_front();
      if (flux !== e.flux) begin
        $display("%0t: face_flux mismatch: expected %h, got %h", $time, e.flux, flux);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated mismatch: expected %b, got %b", $time, e.sat, sat);
        errors++;
      end
    endfunction

    function int pending();
      return pending_fluxes.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                out_valid;
  logic signed [W-1:0] out_face_flux;
  logic                out_saturated;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  stencil_t            stencil_now;
  int                  sender_idle_pct;
  int                  stall_cycles;

  flux_scoreboard fluxes = new();

  muscl_limited_upwind_face_flux_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_far_upwind_value   (stencil_now.far_up),
    .in_near_upwind_value  (stencil_now.near_up),
    .in_near_downwind_value(stencil_now.near_down),
    .in_far_downwind_value (stencil_now.far_down),
    .in_face_velocity      (stencil_now.velocity),
    .out_valid             (out_valid),
    .out_face_flux         (out_face_flux),
    .out_saturated         (out_saturated),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // accept/check on the rising edge; watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst_n && start && !busy) fluxes.note_stencil(stencil_now);
    if (out_valid) fluxes.check_flux(out_face_flux, out_saturated);
    if ((rst_n && start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("muscl_limited_upwind_face_flux_top_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int span(int k);
    return int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k);
  endfunction

  function automatic logic signed [W-1:0] edge_value();
    case ($urandom_range(5))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic stencil_t random_stencil();
    stencil_t s;
    int       base, slope;
    case ($urandom_range(9))
      0, 1: begin
        s.far_up    = $urandom;
        s.near_up   = $urandom;
        s.near_down = $urandom;
        s.far_down  = $urandom;
        s.velocity  = $urandom;
      end
      2, 3, 4, 5: begin
        // smooth profile plus jitter, so limiter branches all get hit
        base        = span(27);
        slope       = span(24);
        s.far_up    = base - slope + span(20);
        s.near_up   = base + span(20);
        s.near_down = base + slope + span(20);
        s.far_down  = base + 2 * slope + span(20);
        s.velocity  = span(25);
      end
      6, 7: begin
        s.far_up    = span(26);
        s.near_up   = span(26);
        s.near_down = span(26);
        s.far_down  = span(26);
        s.velocity  = span(26);
      end
      8: begin
        s.far_up    = edge_value();
        s.near_up   = edge_value();
        s.near_down = edge_value();
        s.far_down  = edge_value();
        s.velocity  = edge_value();
      end
      default: begin
        s.far_up    = $urandom;
        s.near_up   = $urandom;
        s.near_down = $urandom;
        s.far_down  = $urandom;
        s.velocity  = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 1 : -1);
      end
    endcase
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_stencil(input stencil_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    stencil_now = s;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_values(input logic signed [W-1:0] a, b, c, d, uf);
    stencil_t s;
    s.far_up    = a;
    s.near_up   = b;
    s.near_down = c;
    s.far_down  = d;
    s.velocity  = uf;
    send_stencil(s);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (fluxes.pending() > 0) @(negedge clk);
  endtask

  task automatic write_order(input bit en);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = en;
    @(negedge clk);
    cfg_wr_en          = 1'b0;
    fluxes.order_enable = en;
  endtask

  task automatic send_random(input int count, input int idle_pct, input int hold_at);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) wait_drained();
      send_stencil(random_stencil());
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    stencil_now  = '{default: '0};
    sender_idle_pct = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_order(1'b1);
    sender_idle_pct = 29;
    send_values(0, 0, 0, 0, 0);
    send_values(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_values(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_values(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1);            // opposite slopes
    send_values(Q_MIN, Q_MAX, Q_MIN, Q_MAX, -1);
    send_values(3 * Q_ONE, -Q_ONE, 5 * Q_ONE, Q_ONE, 0);   // zero velocity
    send_values(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE);
    send_values(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -Q_ONE);
    send_values(0, Q_ONE >>> 6, 8 * Q_ONE, 9 * Q_ONE, Q_ONE); // slope clipped by 4x
    send_values(Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE);  // zero difference
    send_values(0, 1, 2, 3, Q_ONE);                          // sixth rounds up on tie
    send_values(0, -1, -2, -3, Q_ONE);
    send_values(1 <<< 23, 1 <<< 23, 1 <<< 23, 1 <<< 23, 1);  // product tie
    send_values(1 <<< 23, 1 <<< 23, 1 <<< 23, 1 <<< 23, -1);
    send_values(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX);          // negative clip
    send_values(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_ONE);          // just at upper bound
    send_values(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_ONE);          // just at lower bound
    send_values(Q_MIN, Q_MIN, Q_MIN, Q_MIN, -Q_ONE);         // clips on the + side
    wait_drained();

    write_order(1'b0);
    send_values(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE);
    send_values(0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -Q_ONE);
    send_values(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
    send_values(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
    send_values(5, -7, 9, -11, 0);
    wait_drained();

    write_order(1'b1);
    send_random(250, 29, 120);
    wait_drained();
    write_order(1'b0);
    send_random(100, 83, -1);
    wait_drained();
    write_order(1'b1);
    send_random(250, 0, -1);
    wait_drained();
    repeat (2 * PIPE_LATENCY) @(negedge clk);

    $display("Run covered %0d second-order and %0d first-order stencils,",
             fluxes.n_second, fluxes.n_first);
    $display("including %0d clipped fluxes and %0d zero-velocity faces.",
             fluxes.n_sat, fluxes.n_still);
    if (fluxes.errors == 0 && fluxes.pending() == 0) begin
      $display("muscl_limited_upwind_face_flux_top_tb passed");
    end else begin
      $display("muscl_limited_upwind_face_flux_top_tb failed");
    end
    $finish;
  end

endmodule
